FILE: rtl/swms_pkg.sv
// ----------------------------------------------------------------------------
// swms_pkg: shared types and constants for the sliding window max-sum block
// Fixed field widths, output range limits and the control bundle that the
// top level hands to the accumulator.
// ----------------------------------------------------------------------------
package swms_pkg;

	// window length register width
	localparam int CFG_W = 9;

	// best_sum output width and its signed range
	localparam int OUT_W = 24;
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	// per-cycle control for the accumulator
	typedef struct packed {
		logic take;   // an input item is accepted this cycle
		logic last;   // that item ends the stream
		logic clear;  // window length written: drop the stream under way
	} swms_ctrl_t;

endpackage

FILE: rtl/swms_cell.sv
// ----------------------------------------------------------------------------
// swms_cell: one stage of the sample delay row
// Holds one sample. On a shift it loads the new sample when it is the entry
// tap, else the value of its upper neighbor.
// ----------------------------------------------------------------------------
module swms_cell #(
	parameter int SAMPLE_BITS = 16,
	parameter int IDX_W       = 8,
	parameter int IDX         = 0
) (
	input  logic                   clk,
	input  logic                   shift,
	input  logic [IDX_W-1:0]       tap,
	input  logic [SAMPLE_BITS-1:0] new_sample,
	input  logic [SAMPLE_BITS-1:0] from_upper,
	output logic [SAMPLE_BITS-1:0] value
);

	logic [SAMPLE_BITS-1:0] value_q;
	logic                   is_entry;

	assign is_entry = (tap == IDX_W'(IDX));
	assign value    = value_q;

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= is_entry ? new_sample : from_upper;
		end
	end

endmodule

FILE: rtl/swms_chain.sv
// ----------------------------------------------------------------------------
// swms_chain: row of sample cells forming the window delay line
// A sample enters at cell (len-1) and moves down one cell per accepted item,
// so once the window has filled, cell 0 holds the sample that leaves the window next.
// ----------------------------------------------------------------------------
module swms_chain #(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_WINDOW  = 256,
	parameter int IDX_W       = 8
) (
	input  logic                   clk,
	input  logic                   shift,
	input  logic [IDX_W-1:0]       tap,
	input  logic [SAMPLE_BITS-1:0] new_sample,
	output logic [SAMPLE_BITS-1:0] oldest
);

	logic [SAMPLE_BITS-1:0] cell_val [MAX_WINDOW];

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic [SAMPLE_BITS-1:0] upper;

		if (i == MAX_WINDOW - 1) begin : g_top
			assign upper = new_sample;
		end else begin : g_mid
			assign upper = cell_val[i+1];
		end

		swms_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.IDX_W      (IDX_W),
			.IDX        (i)
		) u_cell (
			.clk       (clk),
			.shift     (shift),
			.tap       (tap),
			.new_sample(new_sample),
			.from_upper(upper),
			.value     (cell_val[i])
		);
	end

	assign oldest = cell_val[0];

endmodule

FILE: rtl/swms_acc.sv
// ----------------------------------------------------------------------------
// swms_acc: running window sum, best sum and result register
// One add, subtract and compare per item; the result sits in an output
// register until the receiver takes it.
// ----------------------------------------------------------------------------
module swms_acc #(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_WINDOW  = 256,
	parameter int LEN_W       = 9
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  swms_pkg::swms_ctrl_t                 ctrl,
	input  logic [LEN_W-1:0]                     len,
	input  logic [SAMPLE_BITS-1:0]               new_sample,
	input  logic [SAMPLE_BITS-1:0]               oldest,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic signed [swms_pkg::OUT_W-1:0]    best_sum,
	output logic                                 found
);

	import swms_pkg::*;

	// exact width of any window sum
	localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);

	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] best_q;
	logic [LEN_W-1:0]        fill_q;

	logic                    full;
	logic                    reach;
	logic [LEN_W-1:0]        fill_inc;
	logic signed [SUM_W-1:0] add_term;
	logic signed [SUM_W-1:0] sub_term;
	logic signed [SUM_W-1:0] sum_nx;
	logic signed [SUM_W-1:0] best_nx;
	logic signed [OUT_W-1:0] best_sat;

	logic                    res_valid_q;
	logic signed [OUT_W-1:0] res_sum_q;
	logic                    res_found_q;

	assign full     = (fill_q == len);
	assign fill_inc = fill_q + LEN_W'(1);
	assign reach    = !full && (fill_inc == len);

	assign add_term = SUM_W'($signed(new_sample));
	assign sub_term = full ? SUM_W'($signed(oldest)) : '0;
	assign sum_nx   = sum_q + add_term - sub_term;

	always_comb begin
		best_nx = best_q;
		if (reach) begin
			best_nx = sum_nx;
		end else if (full && (sum_nx > best_q)) begin
			best_nx = sum_nx;
		end
	end

	// clamp to the output range (only bites when SUM_W exceeds it)
	if (SUM_W <= OUT_W) begin : g_ext
		assign best_sat = OUT_W'(best_nx);
	end else begin : g_sat
		localparam logic signed [SUM_W-1:0] HI = SUM_W'(OUT_MAX);
		localparam logic signed [SUM_W-1:0] LO = SUM_W'(OUT_MIN);
		always_comb begin
			if (best_nx > HI) begin
				best_sat = OUT_MAX;
			end else if (best_nx < LO) begin
				best_sat = OUT_MIN;
			end else begin
				best_sat = OUT_W'(best_nx);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			best_q <= '0;
			fill_q <= '0;
		end else if (ctrl.clear || (ctrl.take && ctrl.last)) begin
			sum_q  <= '0;
			best_q <= '0;
			fill_q <= '0;
		end else if (ctrl.take) begin
			sum_q  <= sum_nx;
			best_q <= best_nx;
			if (!full) begin
				fill_q <= fill_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctrl.take && ctrl.last) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take && ctrl.last) begin
			res_found_q <= reach || full;
			res_sum_q   <= (reach || full) ? best_sat : '0;
		end
	end

	assign out_valid = res_valid_q;
	assign best_sum  = res_sum_q;
	assign found     = res_found_q;

endmodule

FILE: rtl/sliding_window_max_sum_top.sv
// ----------------------------------------------------------------------------
// sliding_window_max_sum_top: largest sum of window_len consecutive samples
// Streams signed samples, keeps the last window_len of them in a row of
// cells, and reports the best window sum when the last sample arrives.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, sample, last): one item per sample,
//   last marks the end of a stream. Up to one item per clock is taken.
//   Output channel (out_valid/out_ready, best_sum, found): one item per
//   stream, registered, valid the cycle after the last sample is taken.
//   found is low (and best_sum zero) when the stream was shorter than
//   the window.
//   Config: window_len is written when window_len_we is high; the user
//   must write it only while idle, the block itself does not enforce it.
//   Zero acts as 1, values above MAX_WINDOW act as MAX_WINDOW. A write
//   drops any partial stream. Throughput is one sample per clock except
//   while a last sample is held off (see Stall); per item the sum path does
//   one add, one subtract and one compare, and the delay row shifts once.
//   Stall: while a result waits on out_ready, non-last samples keep flowing;
//   a last sample is held off until the waiting result is taken.
//   Reset: window_len returns to 4 (clamped to MAX_WINDOW), stream state
//   clears. The delay row is not reset; it is only read once refilled.
// ----------------------------------------------------------------------------
module sliding_window_max_sum_top #(
	parameter int MAX_WINDOW  = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config
	input  logic                                 window_len_we,
	input  logic [swms_pkg::CFG_W-1:0]           window_len,
	// sample stream
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	input  logic                                 last,
	// results
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [swms_pkg::OUT_W-1:0]    best_sum,
	output logic                                 found
);

	import swms_pkg::*;

	localparam int LEN_W = $clog2(MAX_WINDOW + 1);
	localparam int IDX_W = $clog2(MAX_WINDOW);
	// power-on window length, clamped for small MAX_WINDOW
	localparam int RST_LEN = (MAX_WINDOW < 4) ? MAX_WINDOW : 4;

	logic [LEN_W-1:0]       len_q;   // effective window length
	logic [IDX_W-1:0]       tap_q;   // entry cell, len - 1
	int                     eff_len;
	logic                   take;
	swms_ctrl_t             ctrl;
	logic [SAMPLE_BITS-1:0] oldest;

	// clamp the written length once, at the write
	always_comb begin
		eff_len = int'(window_len);
		if (eff_len == 0) begin
			eff_len = 1;
		end else if (eff_len > MAX_WINDOW) begin
			eff_len = MAX_WINDOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(RST_LEN);
			tap_q <= IDX_W'(RST_LEN - 1);
		end else if (window_len_we) begin
			len_q <= LEN_W'(eff_len);
			tap_q <= IDX_W'(eff_len - 1);
		end
	end

	// a last item needs the result register free (or being emptied)
	assign in_ready = !out_valid || out_ready || !last;
	assign take     = in_valid && in_ready;

	assign ctrl.take  = take;
	assign ctrl.last  = last;
	assign ctrl.clear = window_len_we;

	swms_chain #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_WINDOW (MAX_WINDOW),
		.IDX_W      (IDX_W)
	) u_chain (
		.clk       (clk),
		.shift     (take),
		.tap       (tap_q),
		.new_sample(sample),
		.oldest    (oldest)
	);

	swms_acc #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_WINDOW (MAX_WINDOW),
		.LEN_W      (LEN_W)
	) u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.len       (len_q),
		.new_sample(sample),
		.oldest    (oldest),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.best_sum  (best_sum),
		.found     (found)
	);

endmodule

FILE: rtl/swms_checker.sv
// ----------------------------------------------------------------------------
// swms_checker: port-level checks for the sliding window max-sum block
// Watches the top level's channels and flags hold, zero-sum and result slips.
// ----------------------------------------------------------------------------
module swms_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic signed [SAMPLE_BITS-1:0]        sample,
	input logic                                 last,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [swms_pkg::OUT_W-1:0]    best_sum,
	input logic                                 found
);

	// a waiting input item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(sample) && $stable(last))
		else $error("input item changed while waiting");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(best_sum) && $stable(found))
		else $error("result changed while stalled");

	// no full window means a zero sum
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> best_sum == '0)
		else $error("best_sum nonzero without a full window");

	// every last item yields a result next cycle
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last |=> out_valid)
		else $error("no result after last item");

	// no result appears without a last item
	a_spur: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !(in_valid && in_ready && last) |=> !out_valid)
		else $error("result without a last item");

endmodule

bind sliding_window_max_sum_top swms_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_swms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.sample       (sample),
	.last         (last),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.best_sum     (best_sum),
	.found        (found)
);
